@@ hw/rtl/arc4kg_pkg.sv @@
package arc4kg_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int ACTION_W    = 3;

    localparam logic [ADDR_W-1:0] LAST_ROUND = ADDR_W'(TABLE_DEPTH - 1);

    // Action codes carried in the request item
    localparam logic [ACTION_W-1:0] ACT_CLEAR_KEY  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_KEY_BYTE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SCHEDULE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOAD_STATE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_KEYSTREAM  = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   value;
        logic [ADDR_W-1:0]   index;
    } req_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_keystream;
    } rsp_item_t;

    // Access request to one byte memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              clr;
    } ram_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_WR,
        ST_SCH_RD,
        ST_SCH_J,
        ST_SCH_WN,
        ST_SCH_WJ,
        ST_KS_J,
        ST_KS_T,
        ST_KS_W,
        ST_DONE
    } ctrl_state_t;

endpackage

@@ hw/rtl/arc4kg_ram.sv @@
module arc4kg_ram (
    input  logic                                clk,
    input  logic                                rst_n,
    input  arc4kg_pkg::ram_req_t                req,
    output logic [arc4kg_pkg::BYTE_W-1:0]       rd_data,
    output logic                                rd_vld
);
    import arc4kg_pkg::*;

    logic [BYTE_W-1:0]      mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [BYTE_W-1:0]      rd_data_reg;
    logic                   rd_vld_reg;

    // Write and read the byte array; read returns the old contents
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    // Track written entries; clear drops all of them at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.we)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_vld_reg <= vld_reg[req.raddr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_vld  = rd_vld_reg;

endmodule

@@ hw/rtl/arc4kg_ctrl.sv @@
module arc4kg_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  arc4kg_pkg::req_item_t               req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output arc4kg_pkg::rsp_item_t               rsp,
    output arc4kg_pkg::ram_req_t                perm_req,
    input  logic [arc4kg_pkg::BYTE_W-1:0]       perm_rd_data,
    input  logic                                perm_rd_vld,
    output arc4kg_pkg::ram_req_t                key_req,
    input  logic [arc4kg_pkg::BYTE_W-1:0]       key_rd_data,
    input  logic                                key_rd_vld
);
    import arc4kg_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] pos_i_reg, pos_i_next;
    logic [ADDR_W-1:0] acc_j_reg, acc_j_next;
    logic [ADDR_W-1:0] n_reg, n_next;
    logic [BYTE_W-1:0] a_reg, a_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0] perm_raddr_reg, perm_raddr_next;
    logic              out_valid_reg, out_valid_next;
    rsp_item_t         out_data_reg, out_data_next;

    logic              accept;
    logic              out_free;
    logic              post;
    rsp_item_t         post_data;
    logic [BYTE_W-1:0] perm_val;
    logic [BYTE_W-1:0] key_val;
    logic [BYTE_W-1:0] sch_j;
    logic [BYTE_W-1:0] ks_j;
    logic [BYTE_W-1:0] ks_t;
    logic [BYTE_W-1:0] ks_addr;
    logic [BYTE_W-1:0] ks_byte;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;

    // Unwritten entries read as identity (perm) or zero (key)
    assign perm_val = perm_rd_vld ? perm_rd_data : perm_raddr_reg;
    assign key_val  = key_rd_vld ? key_rd_data : '0;

    assign sch_j   = BYTE_W'(acc_j_reg + perm_val + key_val);
    assign ks_j    = BYTE_W'(acc_j_reg + perm_val);
    assign ks_t    = BYTE_W'(a_reg + perm_val);
    assign ks_addr = BYTE_W'(a_reg + b_reg);

    // Forward the two swap writes onto the output lookup
    always_comb
    begin
        if (ks_addr == acc_j_reg)
        begin
            ks_byte = a_reg;
        end
        else if (ks_addr == pos_i_reg)
        begin
            ks_byte = b_reg;
        end
        else
        begin
            ks_byte = perm_val;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_KEY_BYTE:  state_next = ST_KEY_WR;
                        ACT_SCHEDULE:  state_next = ST_SCH_RD;
                        ACT_KEYSTREAM: state_next = ST_KS_J;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_KEY_WR: state_next = out_free ? ST_IDLE : ST_KEY_WR;
            ST_SCH_RD: state_next = ST_SCH_J;
            ST_SCH_J:  state_next = ST_SCH_WN;
            ST_SCH_WN: state_next = ST_SCH_WJ;
            ST_SCH_WJ: state_next = (n_reg == LAST_ROUND) ? ST_DONE : ST_SCH_RD;
            ST_KS_J:   state_next = ST_KS_T;
            ST_KS_T:   state_next = ST_KS_W;
            ST_KS_W:   state_next = out_free ? ST_IDLE : ST_KS_W;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory requests and datapath updates
    always_comb
    begin
        perm_req   = '0;
        key_req    = '0;
        pos_i_next = pos_i_reg;
        acc_j_next = acc_j_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        value_next = value_reg;
        post       = 1'b0;
        post_data  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next = req.value;
                    case (req.action)
                        ACT_CLEAR_KEY:
                        begin
                            key_req.clr = 1'b1;
                            pos_i_next  = '0;
                        end
                        ACT_KEY_BYTE:
                        begin
                            key_req.re    = 1'b1;
                            key_req.raddr = pos_i_reg;
                        end
                        ACT_SCHEDULE:
                        begin
                            perm_req.clr = 1'b1;
                            acc_j_next   = '0;
                            n_next       = '0;
                        end
                        ACT_LOAD_STATE:
                        begin
                            perm_req.we    = 1'b1;
                            perm_req.waddr = req.index;
                            perm_req.wdata = req.value;
                            pos_i_next     = '0;
                            acc_j_next     = '0;
                        end
                        ACT_KEYSTREAM:
                        begin
                            pos_i_next     = ADDR_W'(pos_i_reg + 1'b1);
                            perm_req.re    = 1'b1;
                            perm_req.raddr = ADDR_W'(pos_i_reg + 1'b1);
                        end
                        default:
                        begin
                            value_next = req.value;
                        end
                    endcase
                end
            end
            ST_KEY_WR:
            begin
                // Fold the key byte in; rewriting while stalled is harmless
                key_req.we    = 1'b1;
                key_req.waddr = pos_i_reg;
                key_req.wdata = key_val ^ value_reg;
                post          = out_free;
                if (out_free)
                begin
                    pos_i_next = ADDR_W'(pos_i_reg + 1'b1);
                end
            end
            ST_SCH_RD:
            begin
                perm_req.re    = 1'b1;
                perm_req.raddr = n_reg;
                key_req.re     = 1'b1;
                key_req.raddr  = n_reg;
            end
            ST_SCH_J:
            begin
                a_next         = perm_val;
                acc_j_next     = sch_j;
                perm_req.re    = 1'b1;
                perm_req.raddr = sch_j;
            end
            ST_SCH_WN:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = n_reg;
                perm_req.wdata = perm_val;
            end
            ST_SCH_WJ:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = acc_j_reg;
                perm_req.wdata = a_reg;
                n_next         = ADDR_W'(n_reg + 1'b1);
                if (n_reg == LAST_ROUND)
                begin
                    pos_i_next = '0;
                    acc_j_next = '0;
                end
            end
            ST_KS_J:
            begin
                a_next         = perm_val;
                acc_j_next     = ks_j;
                perm_req.re    = 1'b1;
                perm_req.raddr = ks_j;
            end
            ST_KS_T:
            begin
                b_next         = perm_val;
                perm_req.we    = 1'b1;
                perm_req.waddr = pos_i_reg;
                perm_req.wdata = perm_val;
                perm_req.re    = 1'b1;
                perm_req.raddr = ks_t;
            end
            ST_KS_W:
            begin
                perm_req.we            = 1'b1;
                perm_req.waddr         = acc_j_reg;
                perm_req.wdata         = a_reg;
                post                   = out_free;
                post_data.out_byte     = ks_byte;
                post_data.is_keystream = 1'b1;
            end
            ST_DONE:
            begin
                post = out_free;
            end
            default:
            begin
                post = 1'b0;
            end
        endcase
    end

    // Output register: load on post, drop when taken
    always_comb
    begin
        perm_raddr_next = perm_req.re ? perm_req.raddr : perm_raddr_reg;
        out_data_next   = post ? post_data : out_data_reg;
        if (post)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_i_reg     <= '0;
            acc_j_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_i_reg     <= pos_i_next;
            acc_j_reg     <= acc_j_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        value_reg      <= value_next;
        perm_raddr_reg <= perm_raddr_next;
        out_data_reg   <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        post |-> (!out_valid_reg || rsp_ready))
        else $error("result posted over an untaken item");

    a_wr_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(perm_req.we && perm_req.clr) && !(key_req.we && key_req.clr))
        else $error("memory write collides with clear");

    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCH_WJ && n_reg == LAST_ROUND)
        |=> (state_reg == ST_DONE && pos_i_reg == '0 && acc_j_reg == '0))
        else $error("schedule did not end with zeroed indexes");

    a_idle_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (perm_req.clr || key_req.clr) |-> accept)
        else $error("memory cleared outside an accepted item");

endmodule

@@ hw/rtl/arc4_keystream_generator_unit.sv @@
// ARC4 keystream engine. One request item (action, value, index) gives one
// response item (out_byte, is_keystream). The schedule runs 256 rounds,
// each paced by the single read and single write port of the permutation
// memory, which each round's read, read, write, write sequence occupies.
// A new request is taken in the cycle after the previous one has posted
// its response; a posted response may wait for rsp_ready while the next
// request runs. Both 256-byte memories carry per-entry written flags, so
// reset and the clear/identity fills need no clearing pass.
module arc4_keystream_generator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  arc4kg_pkg::req_item_t     req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output arc4kg_pkg::rsp_item_t     rsp
);
    import arc4kg_pkg::*;

    ram_req_t          perm_req;
    ram_req_t          key_req;
    logic [BYTE_W-1:0] perm_rd_data;
    logic              perm_rd_vld;
    logic [BYTE_W-1:0] key_rd_data;
    logic              key_rd_vld;

    // Sequence the actions over both memories
    arc4kg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .perm_req     (perm_req),
        .perm_rd_data (perm_rd_data),
        .perm_rd_vld  (perm_rd_vld),
        .key_req      (key_req),
        .key_rd_data  (key_rd_data),
        .key_rd_vld   (key_rd_vld)
    );

    // Permutation state
    arc4kg_ram u_perm_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (perm_req),
        .rd_data (perm_rd_data),
        .rd_vld  (perm_rd_vld)
    );

    // Folded key buffer
    arc4kg_ram u_key_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (key_req),
        .rd_data (key_rd_data),
        .rd_vld  (key_rd_vld)
    );

endmodule
